@@ rtl/gmsn_pkg.sv @@
// Shared types and constants for the grid mesh smooth normal block.
`timescale 1ns / 1ps
`default_nettype none

package gmsn_pkg;

    localparam int MAX_SIDE        = 256;
    localparam int SQRT_ITERATIONS = 16;
    localparam int ROOT_ITERS      = (SQRT_ITERATIONS > 32) ? 32 : SQRT_ITERATIONS;

    localparam int COL_W     = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W    = COL_W + 1;
    localparam int RAM_DEPTH = 2 * MAX_SIDE;
    localparam int SIDE_W    = 9;
    localparam int SPACING_W = 16;
    localparam int HEIGHT_W  = 16;
    localparam int NORM_W    = 16;
    localparam int SUM_W     = 18;
    localparam int VEC_W     = 20;
    localparam int DIV_BITS  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING = 1'b1;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } nrm_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum_t;

    typedef struct packed {
        logic start;
        vec_t vec;
    } norm_req_t;

    typedef struct packed {
        logic done;
        nrm_t n;
    } norm_rsp_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQUARE,
        N_ROOT,
        N_DIV
    } norm_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_FACE_REQ,
        S_FACE_WAIT,
        S_ACCUM,
        S_WRITE,
        S_EMIT_REQ,
        S_EMIT_WAIT,
        S_OUT
    } top_state_t;

endpackage

`default_nettype wire

@@ rtl/gmsn_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module gmsn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/gmsn_norm.sv @@
// Iterative vector normalizer: scale, sum of squares, bit-serial root, bit-serial divide.
`timescale 1ns / 1ps
`default_nettype none

module gmsn_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  gmsn_pkg::norm_req_t req,
    output gmsn_pkg::norm_rsp_t rsp
);
    import gmsn_pkg::*;

    localparam int MAG_W  = VEC_W;
    localparam int NUM_W  = 47;
    localparam int REM_W  = 36;
    localparam int CNT_W  = $clog2(((ROOT_ITERS > DIV_BITS) ? ROOT_ITERS : DIV_BITS) + 1);

    norm_state_t state_reg, state_next;
    logic done_reg, done_next;

    logic [2:0][MAG_W-1:0]  mag_reg, mag_next;
    logic [2:0]             neg_reg, neg_next;
    logic [1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [31:0]            acc_reg, acc_next;
    logic [63:0]            x_reg, x_next;
    logic [31:0]            q_reg, q_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [31:0]            root_reg, root_next;
    logic [32:0]            drem_reg, drem_next;
    logic [DIV_BITS-1:0]    dlow_reg, dlow_next;
    logic [DIV_BITS-1:0]    quo_reg, quo_next;
    logic [2:0][NORM_W-1:0] res_reg, res_next;

    logic [2:0][VEC_W-1:0]  in_vec;
    logic                   any_hi, all_lo;
    logic [29:0]            sq;
    logic [REM_W-1:0]       rem_sh, trial;
    logic [31:0]            root_v;
    logic [NUM_W-1:0]       num;
    logic [32:0]            dtrial;
    logic [DIV_BITS-1:0]    sat;

    assign in_vec[0] = req.vec.x;
    assign in_vec[1] = req.vec.y;
    assign in_vec[2] = req.vec.z;

    always_comb
    begin
        any_hi = 1'b0;
        all_lo = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            any_hi = any_hi | (|mag_reg[i][MAG_W-1:15]);
            all_lo = all_lo & ~(|mag_reg[i][MAG_W-1:14]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        drem_next  = drem_reg;
        dlow_next  = dlow_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        sq         = '0;
        rem_sh     = '0;
        trial      = '0;
        root_v     = '0;
        num        = '0;
        dtrial     = '0;
        sat        = '0;
        unique case (state_reg)
            N_IDLE:
            begin
                if (req.start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = in_vec[i][VEC_W-1];
                        mag_next[i] = in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : in_vec[i];
                    end
                    if (in_vec == '0)
                    begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = N_SHIFT;
                    end
                end
            end
            N_SHIFT:
            begin
                // bring the largest magnitude into [2^14, 2^15)
                if (any_hi)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (all_lo)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    state_next = N_SQUARE;
                    idx_next   = 2'd0;
                    acc_next   = '0;
                end
            end
            N_SQUARE:
            begin
                sq       = mag_reg[idx_reg][14:0] * mag_reg[idx_reg][14:0];
                acc_next = acc_reg + 32'(sq);
                if (idx_reg == 2'd2)
                begin
                    state_next = N_ROOT;
                    x_next     = {acc_next, 32'd0};
                    q_next     = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            N_ROOT:
            begin
                // restoring square root, two radicand bits per step
                rem_sh = {rem_reg[REM_W-3:0], x_reg[63:62]};
                trial  = {2'b00, q_reg, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next = rem_sh - trial;
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[30:0], 1'b0};
                end
                x_next   = {x_reg[61:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_ITERS - 1))
                begin
                    root_v     = q_next << (32 - ROOT_ITERS);
                    root_next  = (root_v == '0) ? 32'd1 : root_v;
                    state_next = N_DIV;
                    idx_next   = 2'd0;
                    cnt_next   = '0;
                end
            end
            N_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    // rounded numerator; its top part is already below the divisor
                    num       = (NUM_W'(mag_reg[idx_reg][14:0]) << 30) + NUM_W'(root_reg >> 1);
                    drem_next = {2'b00, num[NUM_W-1:DIV_BITS]};
                    dlow_next = num[DIV_BITS-1:0];
                    quo_next  = '0;
                    cnt_next  = CNT_W'(1);
                end
                else
                begin
                    dtrial = {drem_reg[31:0], dlow_reg[DIV_BITS-1]};
                    if (dtrial >= {1'b0, root_reg})
                    begin
                        drem_next = dtrial - {1'b0, root_reg};
                        quo_next  = {quo_reg[DIV_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_next = dtrial;
                        quo_next  = {quo_reg[DIV_BITS-2:0], 1'b0};
                    end
                    dlow_next = dlow_reg << 1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_BITS))
                    begin
                        sat = (quo_next > DIV_BITS'(16384)) ? DIV_BITS'(16384) : quo_next;
                        res_next[idx_reg] = neg_reg[idx_reg] ? NORM_W'(-sat) : NORM_W'(sat);
                        cnt_next = '0;
                        if (idx_reg == 2'd2)
                        begin
                            state_next = N_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        drem_reg <= drem_next;
        dlow_reg <= dlow_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.n.x  = res_reg[0];
    assign rsp.n.y  = res_reg[1];
    assign rsp.n.z  = res_reg[2];

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == N_IDLE)
        else $error("normalizer done outside idle");

    a_shift_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == N_SHIFT |-> mag_reg != '0)
        else $error("scaling a zero vector");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rsp.n.x <= 16384 && rsp.n.x >= -16384
                   && rsp.n.y <= 16384 && rsp.n.y >= -16384
                   && rsp.n.z <= 16384 && rsp.n.z >= -16384))
        else $error("normal component out of range");

endmodule

`default_nettype wire

@@ rtl/grid_mesh_smooth_normals.sv @@
// Top level: streamed heightmap in, smooth per-vertex unit normals out.
//
//  channel | direction | handshake              | beat payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | in        | in_valid / in_stall    | height
//  out     | out       | out_valid / out_stall  | vert_col vert_row normal_x/y/z grid_done
//  cfg     | in        | cfg_we (no handshake)  | cfg_index cfg_data
//
// A beat that completes no quad (first row or first column) is taken without leaving idle.
// A beat that completes a quad runs two face normalizations and then k = 1..4 emitted
// normals, one after another on the shared unit (scaling shifts, 3 squares,
// SQRT_ITERATIONS root steps, 3 x 17 divide steps for each normalization).
// Reset clears counters and loads side 100, spacing 256; no memory clearing pass.
// in_stall is high whenever a beat is in progress; out_stall simply holds the output.
`timescale 1ns / 1ps
`default_nettype none

module grid_mesh_smooth_normals (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [gmsn_pkg::HEIGHT_W-1:0] height,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         vert_col,
    output logic [7:0]                         vert_row,
    output logic signed [gmsn_pkg::NORM_W-1:0] normal_x,
    output logic signed [gmsn_pkg::NORM_W-1:0] normal_y,
    output logic signed [gmsn_pkg::NORM_W-1:0] normal_z,
    output logic                               grid_done,
    input  logic                               cfg_we,
    input  logic [gmsn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gmsn_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gmsn_pkg::*;

    localparam int SUM_ROW_W = 3 * SUM_W;

    function automatic sum_t add_norm(sum_t s, nrm_t n);
        sum_t r;
        r.x = s.x + SUM_W'(n.x);
        r.y = s.y + SUM_W'(n.y);
        r.z = s.z + SUM_W'(n.z);
        return r;
    endfunction

    top_state_t state_reg, state_next;

    // control
    logic [COL_W-1:0]     col_reg, col_next;
    logic [COL_W-1:0]     row_reg, row_next;
    logic [SIDE_W-1:0]    side_reg, side_next;
    logic [SPACING_W-1:0] spacing_reg, spacing_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 face_reg, face_next;
    logic [1:0]           emit_reg, emit_next;
    logic [3:0]           emit_en_reg, emit_en_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic signed [HEIGHT_W-1:0] h_reg, h_next;
    logic signed [HEIGHT_W-1:0] hup0_reg, hup0_next;   // upper row, column c-1
    logic signed [HEIGHT_W-1:0] hlow0_reg, hlow0_next; // lower row, column c-1
    logic signed [HEIGHT_W-1:0] hup1_reg, hup1_next;   // upper row, column c
    sum_t sup0_reg, sup0_next, slow0_reg, slow0_next, sup1_reg, sup1_next;
    nrm_t n1_reg, n1_next, n2_reg, n2_next;
    sum_t u0_reg, u0_next, u1_reg, u1_next, l0_reg, l0_next, l1_reg, l1_next;
    logic [COL_W-1:0] out_col_reg, out_col_next, out_row_reg, out_row_next;
    nrm_t             out_n_reg, out_n_next;
    logic             out_done_reg, out_done_next;

    // memories
    logic                 hram_we;
    logic [ADDR_W-1:0]    hram_waddr;
    logic [HEIGHT_W-1:0]  hram_rdata;
    logic                 sram_we;
    logic [ADDR_W-1:0]    sram_waddr;
    logic [SUM_ROW_W-1:0] sram_wdata;
    logic [SUM_ROW_W-1:0] sram_rdata;
    logic [ADDR_W-1:0]    raddr;

    norm_req_t norm_req;
    norm_rsp_t norm_rsp;

    logic             lb, ub;
    logic [COL_W-1:0] side_m1, cm1, rm1;
    logic             last_c, last_r, adv;
    vec_t             f1, f2;
    sum_t             emit_sum, rd_sum;
    logic [COL_W-1:0] emit_col, emit_row;

    // rows ping-pong between two banks by row parity
    assign lb = row_reg[0];
    assign ub = ~row_reg[0];
    assign cm1 = col_reg - 1'b1;
    assign rm1 = row_reg - 1'b1;

    always_comb
    begin
        if (side_reg < SIDE_W'(2))
        begin
            side_m1 = COL_W'(1);
        end
        else if (32'(side_reg) > 32'(MAX_SIDE))
        begin
            side_m1 = COL_W'(MAX_SIDE - 1);
        end
        else
        begin
            side_m1 = COL_W'(side_reg - 1'b1);
        end
    end

    assign last_c = (col_reg == side_m1);
    assign last_r = (row_reg == side_m1);
    assign rd_sum = sram_rdata;

    // face vectors, cross products scaled down by the spacing
    always_comb
    begin
        f1.x = VEC_W'(hlow0_reg) - VEC_W'(h_reg);
        f1.y = VEC_W'(spacing_reg);
        f1.z = VEC_W'(hup0_reg) - VEC_W'(hlow0_reg);
        f2.x = VEC_W'(hup0_reg) - VEC_W'(hup1_reg);
        f2.y = VEC_W'(spacing_reg);
        f2.z = VEC_W'(hup1_reg) - VEC_W'(h_reg);
    end

    always_comb
    begin
        unique case (emit_reg)
            2'd0:
            begin
                emit_sum = u0_reg;
                emit_col = cm1;
                emit_row = rm1;
            end
            2'd1:
            begin
                emit_sum = u1_reg;
                emit_col = col_reg;
                emit_row = rm1;
            end
            2'd2:
            begin
                emit_sum = l0_reg;
                emit_col = cm1;
                emit_row = row_reg;
            end
            default:
            begin
                emit_sum = l1_reg;
                emit_col = col_reg;
                emit_row = row_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    raddr = {ub, cm1};
            2'd1:    raddr = {lb, cm1};
            default: raddr = {ub, col_reg};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        face_next      = face_reg;
        emit_next      = emit_reg;
        emit_en_next   = emit_en_reg;
        out_valid_next = out_valid_reg;
        h_next         = h_reg;
        hup0_next      = hup0_reg;
        hlow0_next     = hlow0_reg;
        hup1_next      = hup1_reg;
        sup0_next      = sup0_reg;
        slow0_next     = slow0_reg;
        sup1_next      = sup1_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        u0_next        = u0_reg;
        u1_next        = u1_reg;
        l0_next        = l0_reg;
        l1_next        = l1_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_n_next     = out_n_reg;
        out_done_next  = out_done_reg;
        hram_we        = 1'b0;
        hram_waddr     = {lb, col_reg};
        sram_we        = 1'b0;
        sram_waddr     = {ub, col_reg};
        sram_wdata     = u1_reg;
        norm_req.start = 1'b0;
        norm_req.vec   = f1;
        adv            = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    h_next  = height;
                    hram_we = 1'b1;
                    if (col_reg != '0 && row_reg != '0)
                    begin
                        state_next = S_READ;
                        cnt_next   = 2'd0;
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // sums of a fresh row read as zero: upper before its first quad
                // on row 1, lower on first use
                cnt_next = cnt_reg + 2'd1;
                unique case (cnt_reg)
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        hup0_next = hram_rdata;
                        sup0_next = (row_reg == COL_W'(1) && col_reg == COL_W'(1)) ? '0 : rd_sum;
                    end
                    2'd2:
                    begin
                        hlow0_next = hram_rdata;
                        slow0_next = (col_reg == COL_W'(1)) ? '0 : rd_sum;
                    end
                    default:
                    begin
                        hup1_next  = hram_rdata;
                        sup1_next  = (row_reg == COL_W'(1)) ? '0 : rd_sum;
                        state_next = S_FACE_REQ;
                        face_next  = 1'b0;
                    end
                endcase
            end
            S_FACE_REQ:
            begin
                norm_req.start = 1'b1;
                norm_req.vec   = face_reg ? f2 : f1;
                state_next     = S_FACE_WAIT;
            end
            S_FACE_WAIT:
            begin
                if (norm_rsp.done)
                begin
                    if (face_reg)
                    begin
                        n2_next    = norm_rsp.n;
                        state_next = S_ACCUM;
                    end
                    else
                    begin
                        n1_next    = norm_rsp.n;
                        face_next  = 1'b1;
                        state_next = S_FACE_REQ;
                    end
                end
            end
            S_ACCUM:
            begin
                u0_next    = add_norm(add_norm(sup0_reg, n1_reg), n2_reg);
                u1_next    = add_norm(sup1_reg, n2_reg);
                l0_next    = add_norm(slow0_reg, n1_reg);
                l1_next    = add_norm(add_norm(sum_t'('0), n1_reg), n2_reg);
                state_next = S_WRITE;
                cnt_next   = 2'd0;
            end
            S_WRITE:
            begin
                // upper c-1 is final and never read back
                sram_we  = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                unique case (cnt_reg)
                    2'd0:
                    begin
                        sram_waddr = {ub, col_reg};
                        sram_wdata = u1_reg;
                    end
                    2'd1:
                    begin
                        sram_waddr = {lb, cm1};
                        sram_wdata = l0_reg;
                    end
                    default:
                    begin
                        sram_waddr   = {lb, col_reg};
                        sram_wdata   = l1_reg;
                        state_next   = S_EMIT_REQ;
                        emit_next    = 2'd0;
                        emit_en_next = {last_c && last_r, last_r, last_c, 1'b1};
                    end
                endcase
            end
            S_EMIT_REQ:
            begin
                if (emit_en_reg[emit_reg])
                begin
                    norm_req.start = 1'b1;
                    norm_req.vec.x = VEC_W'(emit_sum.x);
                    norm_req.vec.y = VEC_W'(emit_sum.y);
                    norm_req.vec.z = VEC_W'(emit_sum.z);
                    state_next     = S_EMIT_WAIT;
                end
                else if (emit_reg == 2'd3)
                begin
                    adv        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    emit_next = emit_reg + 2'd1;
                end
            end
            S_EMIT_WAIT:
            begin
                if (norm_rsp.done)
                begin
                    out_col_next   = emit_col;
                    out_row_next   = emit_row;
                    out_n_next     = norm_rsp.n;
                    out_done_next  = (emit_col == side_m1) && (emit_row == side_m1);
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (emit_reg == 2'd3)
                    begin
                        adv        = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_next  = emit_reg + 2'd1;
                        state_next = S_EMIT_REQ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // grid position and configuration; a side write restarts the grid
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        side_next    = side_reg;
        spacing_next = spacing_reg;
        priority if (cfg_we && cfg_index == CFG_GRID_SIDE)
        begin
            side_next = cfg_data[SIDE_W-1:0];
            col_next  = '0;
            row_next  = '0;
        end
        else if (cfg_we && cfg_index == CFG_GRID_SPACING)
        begin
            spacing_next = cfg_data[SPACING_W-1:0];
        end
        else if (adv)
        begin
            if (last_c)
            begin
                col_next = '0;
                row_next = last_r ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            side_reg      <= SIDE_W'(100);
            spacing_reg   <= SPACING_W'(256);
            cnt_reg       <= '0;
            face_reg      <= 1'b0;
            emit_reg      <= '0;
            emit_en_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            side_reg      <= side_next;
            spacing_reg   <= spacing_next;
            cnt_reg       <= cnt_next;
            face_reg      <= face_next;
            emit_reg      <= emit_next;
            emit_en_reg   <= emit_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg        <= h_next;
        hup0_reg     <= hup0_next;
        hlow0_reg    <= hlow0_next;
        hup1_reg     <= hup1_next;
        sup0_reg     <= sup0_next;
        slow0_reg    <= slow0_next;
        sup1_reg     <= sup1_next;
        n1_reg       <= n1_next;
        n2_reg       <= n2_next;
        u0_reg       <= u0_next;
        u1_reg       <= u1_next;
        l0_reg       <= l0_next;
        l1_reg       <= l1_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_n_reg    <= out_n_next;
        out_done_reg <= out_done_next;
    end

    gmsn_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (RAM_DEPTH)
    ) u_height_ram (
        .clk   (clk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (height),
        .raddr (raddr),
        .rdata (hram_rdata)
    );

    gmsn_ram #(
        .WIDTH (SUM_ROW_W),
        .DEPTH (RAM_DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .raddr (raddr),
        .rdata (sram_rdata)
    );

    gmsn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (norm_req),
        .rsp   (norm_rsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign vert_col  = 8'(out_col_reg);
    assign vert_row  = 8'(out_row_reg);
    assign normal_x  = out_n_reg.x;
    assign normal_y  = out_n_reg.y;
    assign normal_z  = out_n_reg.z;
    assign grid_done = out_done_reg;

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT)
        else $error("output beat outside output state");

    a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        norm_req.start |=> !norm_req.start)
        else $error("normalizer started twice in a row");

    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(norm_rsp.done))
        else $error("output beat without a finished normal");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench for grid_mesh_smooth_normals: streams heights and checks every vertex normal.
`timescale 1ns / 1ps

module tb;
    import gmsn_pkg::*;

    // Clock, reset and block ports
    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [HEIGHT_W-1:0]   height;
    logic                         out_valid;
    logic                         out_stall;
    logic [7:0]                   vert_col;
    logic [7:0]                   vert_row;
    logic signed [NORM_W-1:0]     normal_x;
    logic signed [NORM_W-1:0]     normal_y;
    logic signed [NORM_W-1:0]     normal_z;
    logic                         grid_done;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    grid_mesh_smooth_normals u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .height    (height),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .vert_col  (vert_col),
        .vert_row  (vert_row),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .grid_done (grid_done),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // One expected vertex normal
    typedef struct {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        done;
    } vert_nrm_t;

    // Scoreboard: keeps its own copy of the grid state and predicts the
    // normals each accepted height releases, then checks beats in order.
    class normal_scoreboard;
        int          side_reg;
        int          spacing;
        int          up_h[MAX_SIDE];
        int          lo_h[MAX_SIDE];
        int          up_s[MAX_SIDE][3];
        int          lo_s[MAX_SIDE][3];
        int          col_cnt;
        int          row_cnt;
        vert_nrm_t   pending_q[$];
        int          errors;
        int          heights_seen;
        int          normals_seen;
        int          grids_seen;

        function new();
            side_reg = 100;
            spacing  = 256;
            errors = 0;
            heights_seen = 0;
            normals_seen = 0;
            grids_seen = 0;
            foreach (up_h[i])
            begin
                up_h[i] = 0;
                lo_h[i] = 0;
            end
            clear_grid();
        endfunction

        function void clear_grid();
            col_cnt = 0;
            row_cnt = 0;
            foreach (up_s[i, j])
            begin
                up_s[i][j] = 0;
                lo_s[i][j] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_GRID_SIDE)
            begin
                side_reg = val & 16'h01FF;
                clear_grid();
            end
            else
                spacing = val;
        endfunction

        function int used_side();
            if (side_reg < 2) return 2;
            if (side_reg > MAX_SIDE) return MAX_SIDE;
            return side_reg;
        endfunction

        // Scale to [2^14, 2^15), bitwise root of the squared length, rounded divide.
        function void make_unit(input longint v[3], output int res[3]);
            longint unsigned mag[3];
            longint unsigned m;
            longint unsigned s;
            longint unsigned x;
            longint unsigned root;
            longint unsigned t;
            longint unsigned q;
            bit              neg[3];
            m = 0;
            root = 0;
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = v[i] < 0;
                mag[i] = neg[i] ? -v[i] : v[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0)
            begin
                res = '{0, 0, 0};
                return;
            end
            while (m >= 32768)
            begin
                m = m >> 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            while (m < 16384)
            begin
                m = m << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            x = s << 32;
            for (int i = 0; i < ROOT_ITERS; i++)
            begin
                t = root | (64'd1 << (31 - i));
                if (t * t <= x) root = t;
            end
            if (root == 0) root = 1;
            for (int i = 0; i < 3; i++)
            begin
                q = ((mag[i] << 30) + (root >> 1)) / root;
                if (q > 16384) q = 16384;
                res[i] = neg[i] ? -int'(q) : int'(q);
            end
        endfunction

        function void push_vertex(int c, int r, int sum[3], int side);
            longint    v[3];
            int        n[3];
            vert_nrm_t e;
            for (int i = 0; i < 3; i++) v[i] = sum[i];
            make_unit(v, n);
            e.col  = c[7:0];
            e.row  = r[7:0];
            e.nx   = n[0][15:0];
            e.ny   = n[1][15:0];
            e.nz   = n[2][15:0];
            e.done = (c == side - 1) && (r == side - 1);
            pending_q.insert(pending_q.size(), e);
        endfunction

        // Accepted height: update rows and queue the normals it completes.
        function void note_height(logic signed [HEIGHT_W-1:0] hin);
            int     side;
            int     c;
            int     r;
            int     h;
            longint h1;
            longint ha;
            longint hb;
            longint hd;
            longint f1[3];
            longint f2[3];
            int     n1[3];
            int     n2[3];
            side = used_side();
            c = col_cnt;
            r = row_cnt;
            h = hin;
            heights_seen++;
            if (c >= side) c = side - 1;
            lo_h[c] = h;
            if (c >= 1 && r >= 1)
            begin
                h1 = up_h[c-1];
                ha = lo_h[c-1] - h1;
                hb = h - h1;
                hd = up_h[c] - h1;
                f1 = '{ha - hb, longint'(spacing), -ha};
                f2 = '{-hd, longint'(spacing), hd - hb};
                make_unit(f1, n1);
                make_unit(f2, n2);
                for (int i = 0; i < 3; i++)
                begin
                    up_s[c-1][i] += n1[i] + n2[i];
                    lo_s[c-1][i] += n1[i];
                    lo_s[c][i]   += n1[i] + n2[i];
                    up_s[c][i]   += n2[i];
                end
                push_vertex(c - 1, r - 1, up_s[c-1], side);
                if (c == side - 1) push_vertex(c, r - 1, up_s[c], side);
                if (r == side - 1) push_vertex(c - 1, r, lo_s[c-1], side);
                if (c == side - 1 && r == side - 1) push_vertex(c, r, lo_s[c], side);
            end
            c++;
            if (c >= side)
            begin
                c = 0;
                up_h = lo_h;
                up_s = lo_s;
                foreach (lo_s[i, j]) lo_s[i][j] = 0;
                r++;
                if (r >= side)
                begin
                    r = 0;
                    foreach (up_s[i, j]) up_s[i][j] = 0;
                end
            end
            col_cnt = c;
            row_cnt = r;
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_normal(vert_nrm_t got);
            vert_nrm_t e;
            normals_seen++;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected normal for vertex (%0d,%0d)", got.col, got.row));
                return;
            end
            e = pending_q.pop_front();
            if (got.done) grids_seen++;
            if (got.col !== e.col || got.row !== e.row)
                report($sformatf("vertex (%0d,%0d), expected (%0d,%0d)",
                                 got.col, got.row, e.col, e.row));
            if (got.nx !== e.nx || got.ny !== e.ny || got.nz !== e.nz)
                report($sformatf("normal at (%0d,%0d) %h %h %h, expected %h %h %h",
                                 e.col, e.row, got.nx, got.ny, got.nz, e.nx, e.ny, e.nz));
            if (got.done !== e.done)
                report($sformatf("grid_done at (%0d,%0d) %b, expected %b",
                                 e.col, e.row, got.done, e.done));
        endtask
    endclass

    normal_scoreboard sb;
    int sender_idle;   // percent of cycles the height source holds back
    int rx_stall;      // percent of cycles the normal sink stalls

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sink: random stall changes on the falling edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < rx_stall);

    // Monitor: a beat leaves on a rising edge with valid high and stall low
    always @(posedge clk)
    begin
        vert_nrm_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.col  = vert_col;
            got.row  = vert_row;
            got.nx   = normal_x;
            got.ny   = normal_y;
            got.nz   = normal_z;
            got.done = grid_done;
            sb.check_normal(got);
        end
    end

    // Generous ceiling: far past the slowest legal run
    initial
    begin
        #50_000_000;
        $display("timeout with %0d normals outstanding", sb.pending_q.size());
        $display("grid_mesh_smooth_normals test failed");
        $finish;
    end

    // Drive one height beat; returns just after the edge that accepted it.
    task send_height(logic signed [HEIGHT_W-1:0] h);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        height   = h;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_height(h);
    endtask

    // Wait until every predicted normal has left and the block has gone quiet.
    task drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        while (in_stall) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Register write, only ever issued while drained
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic signed [HEIGHT_W-1:0] rand_height();
        case ($urandom_range(3))
            0:       return 16'($urandom);                          // full range
            1:       return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
            default: return $signed(16'($urandom_range(1023))) - 16'sd512;  // gentle slope
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_spacing();
        case ($urandom_range(4))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(65535, 1));
            default: return 16'($urandom_range(1024, 16));
        endcase
    endfunction

    initial
    begin
        int phase_idle[4];
        int phase_stall[4];
        int sent;
        sb = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        height    = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sender_idle = 0;
        rx_stall    = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: two-by-two grids put all four normals and grid_done on one beat
        write_reg(CFG_GRID_SIDE, 16'd2);
        write_reg(CFG_GRID_SPACING, 16'd1);
        send_height(16'sh8000);
        send_height(16'sh7FFF);
        send_height(16'sh7FFF);
        send_height(16'sh8000);
        // flat patch, then the next grid after the finished one
        send_height(16'sd0);
        send_height(16'sd0);
        send_height(16'sd0);
        send_height(16'sd0);
        drain();
        write_reg(CFG_GRID_SPACING, 16'hFFFF);
        send_height(16'sh7FFF);
        send_height(16'sh8000);
        send_height(16'sh8000);
        send_height(16'sh7FFF);
        drain();
        // side below range acts as two
        write_reg(CFG_GRID_SIDE, 16'd0);
        send_height(16'sd300);
        send_height(-16'sd300);
        send_height(16'sd1);
        send_height(-16'sd1);
        drain();
        // side three, spacing changed halfway through the grid
        write_reg(CFG_GRID_SIDE, 16'd3);
        write_reg(CFG_GRID_SPACING, 16'd256);
        for (int i = 0; i < 4; i++) send_height(rand_height());
        drain();
        write_reg(CFG_GRID_SPACING, 16'd40);
        for (int i = 0; i < 5; i++) send_height(rand_height());
        drain();
        // side above range clamps to the maximum: a few first-row beats only
        write_reg(CFG_GRID_SIDE, 16'h01FF);
        for (int i = 0; i < 5; i++) send_height(rand_height());
        drain();
        write_reg(CFG_GRID_SIDE, 16'd1);
        for (int i = 0; i < 4; i++) send_height(rand_height());
        drain();

        // Random phases: small grids so most beats finish quads and whole grids
        phase_idle  = '{0, 79, 0, 23};
        phase_stall = '{0, 0, 79, 23};
        for (int p = 0; p < 4; p++)
        begin
            sender_idle = phase_idle[p];
            rx_stall    = phase_stall[p];
            sent = 0;
            while (sent < 90)
            begin
                drain();
                if ($urandom_range(9) == 0)
                    write_reg(CFG_GRID_SIDE, 16'($urandom_range(24, 7)));
                else
                    write_reg(CFG_GRID_SIDE, 16'($urandom_range(6, 2)));
                write_reg(CFG_GRID_SPACING, rand_spacing());
                for (int i = 0; i < 30; i++)
                begin
                    // spacing change while idle in the middle of a grid
                    if (i == 15 && $urandom_range(3) == 0)
                    begin
                        drain();
                        write_reg(CFG_GRID_SPACING, rand_spacing());
                    end
                    send_height(rand_height());
                    sent++;
                end
            end
        end
        sender_idle = 0;
        rx_stall    = 0;
        drain();

        foreach (sb.pending_q[i])
            sb.report($sformatf("normal for (%0d,%0d) never arrived",
                                sb.pending_q[i].col, sb.pending_q[i].row));
        $display("covered %0d heights, %0d normals, %0d finished grids, under four idle mixes",
                 sb.heights_seen, sb.normals_seen, sb.grids_seen);
        if (sb.errors == 0)
            $display("grid_mesh_smooth_normals test passed");
        else
            $display("grid_mesh_smooth_normals test failed");
        $finish;
    end

endmodule
